>>> design/srns_pkg.sv
package srns_pkg;

  localparam int unsigned WinDepth  = 5;
  localparam int unsigned FooterLen = WinDepth + 1;
  localparam int unsigned MaxOut    = 8;
  localparam int unsigned FillW     = $clog2(WinDepth + 1);
  localparam int unsigned WinIdxW   = $clog2(WinDepth);
  localparam int unsigned CntW      = $clog2(MaxOut + 1);
  localparam int unsigned IdxW      = $clog2(MaxOut);

  localparam logic [7:0] SymbolLead     = 8'h81;
  localparam logic [7:0] RubyOpenTrail  = 8'h73;
  localparam logic [7:0] BarTrail       = 8'h62;
  localparam logic [7:0] NoteOpenTrail  = 8'h6D;
  localparam logic [7:0] RubyCloseTrail = 8'h74;
  localparam logic [7:0] NoteCloseTrail = 8'h6E;
  localparam logic [7:0] LeadLoA        = 8'h81;
  localparam logic [7:0] LeadHiA        = 8'h9F;
  localparam logic [7:0] LeadLoB        = 8'hE0;
  localparam logic [7:0] LeadHiB        = 8'hFC;

  localparam logic [7:0] FooterMark [FooterLen] = '{8'h92, 8'hEA, 8'h96, 8'h7B, 8'h81, 8'h46};

  typedef enum logic [2:0] {
    SKIP_NONE = 3'b001,
    SKIP_RUBY = 3'b010,
    SKIP_NOTE = 3'b100
  } skip_t;

  typedef struct packed {
    logic [7:0] lead;
    logic       held;
    skip_t      skip;
  } filt_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       text_done;
  } res_t;

  typedef struct packed {
    res_t [MaxOut-1:0] items;
    logic [CntW-1:0]   cnt;
  } batch_t;

  typedef struct packed {
    filt_t      st;
    logic [1:0] n;
    logic [7:0] e0;
    logic [7:0] e1;
  } feed_t;

  function automatic logic is_lead(logic [7:0] b);
    return ((b >= LeadLoA) && (b <= LeadHiA)) || ((b >= LeadLoB) && (b <= LeadHiB));
  endfunction

  // One character-filter step on a body byte.
  function automatic feed_t feed(filt_t s, logic [7:0] c);
    feed_t r;
    logic [7:0] close_trail;
    r.st = s;
    r.n  = 2'd0;
    r.e0 = s.lead;
    r.e1 = c;
    close_trail = (s.skip == SKIP_RUBY) ? RubyCloseTrail : NoteCloseTrail;
    if (!s.held) begin
      r.st.lead = c;
      r.st.held = 1'b1;
    end else if (s.skip == SKIP_NONE) begin
      if (is_lead(s.lead)) begin
        r.st.held = 1'b0;
        if (s.lead == SymbolLead && c == RubyOpenTrail) begin
          r.st.skip = SKIP_RUBY;
        end else if (s.lead == SymbolLead && c == BarTrail) begin
          r.n = 2'd0;
        end else if (s.lead == SymbolLead && c == NoteOpenTrail) begin
          r.st.skip = SKIP_NOTE;
        end else begin
          r.n = 2'd2;
        end
      end else begin
        r.n       = 2'd1;
        r.st.lead = c;
      end
    end else begin
      if (is_lead(s.lead) && c != 8'h00) begin
        r.st.held = 1'b0;
        if (s.lead == SymbolLead && c == close_trail) begin
          r.st.skip = SKIP_NONE;
        end
      end else begin
        r.st.lead = c;
      end
    end
    return r;
  endfunction

  function automatic batch_t push(batch_t l, logic [7:0] b);
    batch_t r;
    r = l;
    if (l.cnt < CntW'(MaxOut)) begin
      r.items[l.cnt[IdxW-1:0]] = '{out_byte: b, byte_valid: 1'b1, text_done: 1'b0};
      r.cnt = l.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic batch_t push_feed(batch_t l, feed_t f);
    batch_t r;
    r = l;
    if (f.n != 2'd0) begin
      r = push(r, f.e0);
    end
    if (f.n == 2'd2) begin
      r = push(r, f.e1);
    end
    return r;
  endfunction

endpackage

>>> design/srns_if.sv
interface srns_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface srns_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       text_done;

  modport source (output valid, output out_byte, output byte_valid, output text_done,
                  input ready);
  modport sink (input valid, input out_byte, input byte_valid, input text_done,
                output ready);
endinterface

>>> design/sjis_ruby_note_stripper.sv
// Shift-JIS ruby/note stripper.
// text_in carries one raw body byte per transaction, with end_of_text on the
// last byte of a text. text_out carries the kept bytes; the final result of a
// text has text_done set (byte_valid low if that text kept nothing there).
// A transaction yields zero to two results, or one to seven with end_of_text.
// The results of an accepted transaction pass through the batch register and
// then the output register to text_out. One byte per cycle is taken while each
// byte gives at most one result and text_out.ready is high; a byte that gives
// more holds the input while the output register drains the batch one a cycle.
// Results travel through a batch register and an output register, so a new
// byte is taken while the output register waits on a stalled receiver; once
// both are full, text_in.ready drops until text_out.ready returns.
// Reset clears the filter, footer search, batch register and output valid flag;
// the raw window holds no valid data after reset or after a text ends.
module sjis_ruby_note_stripper (
  input logic clk,
  input logic rst,
  srns_in_if.sink text_in,
  srns_out_if.source text_out
);
  import srns_pkg::*;

  filt_t            filt;
  logic [FillW-1:0] fill;
  logic             seen;
  logic [7:0]       win [WinDepth];
  batch_t           bq;
  batch_t           bq_next;
  res_t             out_q;
  logic             out_valid;

  filt_t            f;
  feed_t            fr;
  batch_t           lst;
  logic             match;
  logic [7:0]       wn [WinDepth];
  logic [FillW-1:0] fill_next;
  logic             seen_next;
  logic             in_acc;
  logic             move;

  assign move   = (bq.cnt != '0) && (!out_valid || text_out.ready);
  assign text_in.ready = (bq.cnt == '0) || ((bq.cnt == CntW'(1)) && move);
  assign in_acc = text_in.valid && text_in.ready;

  always_comb begin
    match = (fill == FillW'(WinDepth)) && (text_in.in_byte == FooterMark[FooterLen-1]);
    for (int i = 0; i < WinDepth; i++) begin
      if (win[i] != FooterMark[i]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    f         = filt;
    fr        = '0;
    lst       = '0;
    wn        = win;
    fill_next = fill;
    seen_next = seen;
    if (!seen) begin
      if (match) begin
        seen_next = 1'b1;
        if (f.held) begin
          lst = push(lst, f.lead);
        end
        f.held    = 1'b0;
        fill_next = '0;
      end else if (text_in.end_of_text) begin
        for (int i = 0; i < WinDepth; i++) begin
          if (FillW'(i) < fill) begin
            fr  = feed(f, win[i]);
            f   = fr.st;
            lst = push_feed(lst, fr);
          end
        end
        fr        = feed(f, text_in.in_byte);
        f         = fr.st;
        lst       = push_feed(lst, fr);
        fill_next = '0;
      end else if (fill < FillW'(WinDepth)) begin
        wn[fill[WinIdxW-1:0]] = text_in.in_byte;
        fill_next = fill + 1'b1;
      end else begin
        fr  = feed(f, win[0]);
        f   = fr.st;
        lst = push_feed(lst, fr);
        for (int i = 0; i < WinDepth - 1; i++) begin
          wn[i] = win[i+1];
        end
        wn[WinDepth-1] = text_in.in_byte;
      end
    end
    if (text_in.end_of_text) begin
      if (f.held) begin
        lst = push(lst, f.lead);
      end
      if (lst.cnt == '0) begin
        lst.items[0] = '0;
        lst.cnt      = CntW'(1);
      end
      lst.items[IdxW'(lst.cnt - 1'b1)].text_done = 1'b1;
      f         = '{lead: 8'h00, held: 1'b0, skip: SKIP_NONE};
      fill_next = '0;
      seen_next = 1'b0;
    end
  end

  always_comb begin
    bq_next = bq;
    if (in_acc) begin
      bq_next = lst;
    end else if (move) begin
      bq_next.items = {res_t'(0), bq.items[MaxOut-1:1]};
      bq_next.cnt   = bq.cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt      <= '{lead: 8'h00, held: 1'b0, skip: SKIP_NONE};
      fill      <= '0;
      seen      <= 1'b0;
      bq        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        filt <= f;
        fill <= fill_next;
        seen <= seen_next;
      end
      bq <= bq_next;
      if (move) begin
        out_valid <= 1'b1;
      end else if (text_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      win <= wn;
    end
    if (move) begin
      out_q <= bq.items[0];
    end
  end

  assign text_out.valid      = out_valid;
  assign text_out.out_byte   = out_q.out_byte;
  assign text_out.byte_valid = out_q.byte_valid;
  assign text_out.text_done  = out_q.text_done;

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FillW'(WinDepth))
    else $error("raw window fill out of range");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && text_in.end_of_text) |=>
      (fill == '0) && !filt.held && !seen && (filt.skip == SKIP_NONE))
    else $error("state not cleared after end of text");

  a_end_yields: assert property (@(posedge clk) disable iff (rst)
    (in_acc && text_in.end_of_text) |=> (bq.cnt != '0))
    else $error("end of text produced no result");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    ((bq.cnt != '0) && bq.items[0].text_done) |-> (bq.cnt == CntW'(1)))
    else $error("text_done not on last result of batch");

endmodule

>>> test/sjis_ruby_note_stripper_tb.sv
module sjis_ruby_note_stripper_tb;
  import srns_pkg::*;

  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned SqueezeLen  = 60;
  localparam int unsigned RandomBytes = 360;
  localparam int unsigned DrainWait   = 24;

  class text_scoreboard;
    logic [7:0] window [WinDepth];
    int unsigned fill;
    logic [7:0] held_lead;
    bit held_valid;
    skip_t skip;
    bit footer_seen;
    res_t step_out[$];
    res_t due[$];
    int errors;
    int results_checked;
    int texts_done;
    int footers_found;
    int spans_opened;

    function new();
      clear_state();
    endfunction

    function void clear_state();
      fill = 0;
      held_lead = 8'h00;
      held_valid = 1'b0;
      skip = SKIP_NONE;
      footer_seen = 1'b0;
    endfunction

    function bit sjis_lead(logic [7:0] b);
      return (b >= LeadLoA && b <= LeadHiA) || (b >= LeadLoB && b <= LeadHiB);
    endfunction

    function void keep(logic [7:0] b);
      res_t r;
      r.out_byte = b;
      r.byte_valid = 1'b1;
      r.text_done = 1'b0;
      if (step_out.size() < MaxOut) step_out = {step_out, r};
    endfunction

    function void release_held();
      if (held_valid) keep(held_lead);
      held_valid = 1'b0;
    endfunction

    // character filter: pairs a held byte with its successor
    function void filter_char(logic [7:0] c);
      logic [7:0] close_trail;
      if (!held_valid) begin
        held_lead = c;
        held_valid = 1'b1;
        return;
      end
      if (skip == SKIP_NONE) begin
        if (sjis_lead(held_lead)) begin
          held_valid = 1'b0;
          if (held_lead == SymbolLead && c == RubyOpenTrail) begin
            skip = SKIP_RUBY;
            spans_opened++;
          end else if (held_lead == SymbolLead && c == NoteOpenTrail) begin
            skip = SKIP_NOTE;
            spans_opened++;
          end else if (!(held_lead == SymbolLead && c == BarTrail)) begin
            keep(held_lead);
            keep(c);
          end
        end else begin
          keep(held_lead);
          held_lead = c;
        end
      end else begin
        close_trail = (skip == SKIP_RUBY) ? RubyCloseTrail : NoteCloseTrail;
        if (sjis_lead(held_lead) && c != 8'h00) begin
          held_valid = 1'b0;
          if (held_lead == SymbolLead && c == close_trail) skip = SKIP_NONE;
        end else begin
          held_lead = c;
        end
      end
    endfunction

    function void note_input(logic [7:0] b, logic eot);
      bit hit;
      int i;
      res_t last;
      step_out.delete();
      if (!footer_seen) begin
        hit = (fill == WinDepth) && (b == FooterMark[WinDepth]);
        for (i = 0; i < WinDepth; i++)
          if (window[i] != FooterMark[i]) hit = 1'b0;
        if (hit) begin
          footer_seen = 1'b1;
          footers_found++;
          release_held();
          fill = 0;
        end else if (eot) begin
          for (i = 0; i < fill; i++) filter_char(window[i]);
          filter_char(b);
          fill = 0;
        end else if (fill < WinDepth) begin
          window[fill] = b;
          fill++;
        end else begin
          filter_char(window[0]);
          for (i = 0; i < WinDepth - 1; i++) window[i] = window[i + 1];
          window[WinDepth - 1] = b;
        end
      end
      if (eot) begin
        release_held();
        if (step_out.size() == 0) begin
          last.out_byte = 8'h00;
          last.byte_valid = 1'b0;
          last.text_done = 1'b0;
          step_out = {step_out, last};
        end
        step_out[step_out.size() - 1].text_done = 1'b1;
        clear_state();
        texts_done++;
      end
      due = {due, step_out};
    endfunction

    function void check_output(logic [7:0] ob, logic bv, logic td);
      res_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: byte %02h valid %0b done %0b", ob, bv, td);
        return;
      end
      want = due.pop_front();
      results_checked++;
      if (ob !== want.out_byte || bv !== want.byte_valid || td !== want.text_done) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected byte %02h valid %0b done %0b, got byte %02h valid %0b done %0b",
                   want.out_byte, want.byte_valid, want.text_done, ob, bv, td);
      end
    endfunction

    function int outstanding();
      return due.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  srns_in_if text_in();
  srns_out_if text_out();

  sjis_ruby_note_stripper uut (
    .clk(clk),
    .rst(rst),
    .text_in(text_in),
    .text_out(text_out)
  );

  text_scoreboard sb = new();

  bit sender_idle_on = 1'b1;
  bit receiver_idle_on = 1'b1;
  bit squeeze_req = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  logic [7:0] text_q[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    while (sender_idle_on && $urandom_range(99) < 17) begin
      text_in.valid <= 1'b0;
      @(posedge clk);
    end
    text_in.valid <= 1'b1;
    text_in.in_byte <= b;
    text_in.end_of_text <= eot;
    do @(posedge clk); while (text_in.ready !== 1'b1);
    sb.note_input(b, eot);
    bytes_sent++;
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_random_text();
    int tokens;
    int k;
    int n;
    int pick;
    int cut;
    logic [7:0] lead;
    text_q.delete();
    tokens = $urandom_range(1, 10);
    for (k = 0; k < tokens; k++) begin
      pick = $urandom_range(99);
      lead = $urandom_range(1) ? 8'($urandom_range(LeadLoA, LeadHiA))
                               : 8'($urandom_range(LeadLoB, LeadHiB));
      if (pick < 28) begin
        text_q = {text_q, ($urandom_range(1) ? 8'($urandom_range(8'h20, 8'h7E))
                                             : 8'($urandom_range(8'hA1, 8'hDF)))};
      end else if (pick < 52) begin
        text_q = {text_q, lead, 8'($urandom_range(8'h40, 8'hFC))};
      end else if (pick < 60) begin
        text_q = {text_q, SymbolLead, RubyOpenTrail};
      end else if (pick < 66) begin
        text_q = {text_q, SymbolLead, RubyCloseTrail};
      end else if (pick < 72) begin
        text_q = {text_q, SymbolLead, NoteOpenTrail};
      end else if (pick < 77) begin
        text_q = {text_q, SymbolLead, NoteCloseTrail};
      end else if (pick < 81) begin
        text_q = {text_q, SymbolLead, BarTrail};
      end else if (pick < 85) begin
        for (n = 0; n < FooterLen; n++) text_q = {text_q, FooterMark[n]};
      end else if (pick < 87) begin
        // truncated footer mark
        cut = $urandom_range(1, FooterLen - 1);
        for (n = 0; n < cut; n++) text_q = {text_q, FooterMark[n]};
      end else if (pick < 90) begin
        text_q = {text_q, lead, 8'h00};
      end else begin
        text_q = {text_q, 8'($urandom_range(255))};
      end
    end
    send_text();
  endtask

  // receiver: checks results and drives ready
  initial begin
    text_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && text_out.valid === 1'b1 && text_out.ready === 1'b1)
        sb.check_output(text_out.out_byte, text_out.byte_valid, text_out.text_done);
      if (rst) begin
        text_out.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        text_out.ready <= 1'b0;
      end else if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left = SqueezeLen - 1;
        text_out.ready <= 1'b0;
      end else begin
        text_out.ready <= !(receiver_idle_on && $urandom_range(99) < 17);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((text_in.valid === 1'b1 && text_in.ready === 1'b1) ||
          (text_out.valid === 1'b1 && text_out.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 IdleLimit, sb.outstanding());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned random_start;
    rst <= 1'b1;
    text_in.valid <= 1'b0;
    text_in.in_byte <= 8'h00;
    text_in.end_of_text <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bar pair only: nothing kept
    text_q = '{SymbolLead, BarTrail};
    send_text();
    // byte extremes, lone lead at the end
    text_q = '{8'hFF, 8'h00, SymbolLead};
    send_text();
    // ruby span with a pair inside, closed
    text_q = '{SymbolLead, RubyOpenTrail, 8'hE0, 8'h40, SymbolLead, RubyCloseTrail, 8'h41};
    send_text();
    // note span, zero trail, text ends inside the span
    text_q = '{SymbolLead, NoteOpenTrail, 8'h88, 8'h00, NoteCloseTrail};
    send_text();
    // footer completed by the last byte, held byte flushed
    text_q = '{8'h41, FooterMark[0], FooterMark[1], FooterMark[2], FooterMark[3],
               FooterMark[4], FooterMark[5]};
    send_text();
    // footer cut off by the end
    text_q = '{FooterMark[0], FooterMark[1], FooterMark[2], FooterMark[3], FooterMark[4]};
    send_text();

    random_start = bytes_sent;
    squeeze_req = 1'b1;
    while (bytes_sent - random_start < RandomBytes) begin
      sender_idle_on = !(bytes_sent - random_start >= RandomBytes / 3 &&
                         bytes_sent - random_start < 2 * RandomBytes / 3);
      receiver_idle_on = sender_idle_on;
      send_random_text();
    end
    text_in.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("covered %0d texts, %0d bytes in, %0d results checked", sb.texts_done,
             bytes_sent, sb.results_checked);
    $display("footer found in %0d texts, %0d ruby/note spans opened, %0d errors",
             sb.footers_found, sb.spans_opened, sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sjis_ruby_note_stripper.f
design/srns_pkg.sv
design/srns_if.sv
design/sjis_ruby_note_stripper.sv
test/sjis_ruby_note_stripper_tb.sv
